@@ src/assert_macros.svh @@
// Assertion macros shared by the modular inverse block.
// Depends on a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while in reset
`define MIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true
`define MIE_ASSERT_NEVER(lbl, cond, msg) \
  `MIE_ASSERT(lbl, !(cond), msg)

`endif

@@ src/mie_pkg.sv @@
// Shared types and constants for the modular inverse block.
// Used by the controller, the datapath and the top level; no dependencies.
package mie_pkg;

  // Operand width
  localparam int unsigned WIDTH = 32;
  // Bit counter width for one division
  localparam int unsigned CNT_W = $clog2(WIDTH);

  typedef logic [WIDTH-1:0] word_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NOT_COPR = 2'd1,
    STATUS_ZERO_MOD = 2'd2
  } status_e;

  // Input word
  typedef struct packed {
    word_t value;
    word_t modulus;
  } in_word_t;

  // Result word
  typedef struct packed {
    word_t   inverse_out;
    word_t   gcd_out;
    status_e status;
  } out_word_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // take a new operand pair
    logic div_init;  // start a division r0 / r1
    logic div_step;  // one quotient bit
    logic update;    // advance remainders and coefficients
    logic finish;    // register the result word
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic r1_zero;   // divisor is zero
    logic rem_zero;  // division left no remainder
  } dp_status_t;

endpackage

@@ src/mie_ctrl.sv @@
// Controller state machine of the modular inverse block.
// Depends on mie_pkg; drives commands to mie_datapath.
module mie_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  mie_pkg::dp_status_t status_i,
  output mie_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy,
  output logic                done_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_DIV   = 5'b00100,
    S_STEP  = 5'b01000,
    S_FINAL = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  mie_pkg::cnt_t cnt_q, cnt_d;
  logic          done_q, done_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        if (status_i.r1_zero) begin
          state_d = S_FINAL;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = mie_pkg::cnt_t'(mie_pkg::WIDTH - 1);
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_STEP;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_STEP: begin
        if (status_i.rem_zero) begin
          state_d = S_FINAL;
        end else begin
          cmd_o.update = 1'b1;
          state_d      = S_PREP;
        end
      end
      S_FINAL: begin
        cmd_o.finish = 1'b1;
        done_d       = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

@@ src/mie_datapath.sv @@
// Datapath of the modular inverse block: remainders, coefficients,
// a bit-serial restoring divider with Horner multiply-accumulate. Depends on mie_pkg.
module mie_datapath (
  input  logic                clk_i,
  input  mie_pkg::in_word_t   in_word_i,
  input  mie_pkg::ctrl_cmd_t  cmd_i,
  output mie_pkg::dp_status_t status_o,
  output mie_pkg::out_word_t  result_o
);

  localparam int unsigned W = mie_pkg::WIDTH;

  mie_pkg::word_t    r0_q, r1_q, c0_q, c1_q, b_q;
  mie_pkg::word_t    dvd_q, rem_q, acc_q;
  logic              even_q;
  mie_pkg::out_word_t res_q, res_d;

  logic [W:0]        part;
  logic [W:0]        diff;
  logic              q_bit;
  mie_pkg::word_t    rem_next;
  mie_pkg::word_t    acc_next;
  mie_pkg::word_t    mag;
  mie_pkg::word_t    inv;

  // One restoring division step; quotient bit times c1 folded into acc
  always_comb begin
    part     = {rem_q, dvd_q[W-1]};
    diff     = part - {1'b0, r1_q};
    q_bit    = ~diff[W];
    rem_next = q_bit ? diff[W-1:0] : part[W-1:0];
    acc_next = {acc_q[W-2:0], 1'b0} + (q_bit ? c1_q : '0);
  end

  // Reduce coefficient and apply sign from step parity
  always_comb begin
    mag = (c1_q >= b_q) ? (c1_q - b_q) : c1_q;
    if (even_q) begin
      inv = mag;
    end else begin
      inv = (mag == '0) ? '0 : (b_q - mag);
    end
  end

  // Result word
  always_comb begin
    res_d = res_q;
    if (r1_q == '0) begin
      res_d.inverse_out = '0;
      res_d.gcd_out     = r0_q;
      res_d.status      = mie_pkg::STATUS_ZERO_MOD;
    end else if (r1_q != mie_pkg::word_t'(1)) begin
      res_d.inverse_out = '0;
      res_d.gcd_out     = r1_q;
      res_d.status      = mie_pkg::STATUS_NOT_COPR;
    end else begin
      res_d.inverse_out = inv;
      res_d.gcd_out     = r1_q;
      res_d.status      = mie_pkg::STATUS_OK;
    end
  end

  // Euclid state
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r0_q   <= in_word_i.value;
      r1_q   <= in_word_i.modulus;
      b_q    <= in_word_i.modulus;
      c0_q   <= mie_pkg::word_t'(1);
      c1_q   <= '0;
      even_q <= 1'b0;
    end else if (cmd_i.update) begin
      r0_q   <= r1_q;
      r1_q   <= rem_q;
      c0_q   <= c1_q;
      c1_q   <= acc_q + c0_q;
      even_q <= ~even_q;
    end
  end

  // Divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dvd_q <= r0_q;
      rem_q <= '0;
      acc_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[W-2:0], 1'b0};
      rem_q <= rem_next;
      acc_q <= acc_next;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q <= res_d;
    end
  end

  assign status_o.r1_zero  = (r1_q == '0);
  assign status_o.rem_zero = (rem_q == '0);
  assign result_o          = res_q;

endmodule

@@ src/modular_inverse_ext_euclid.sv @@
// Modular inverse by the extended Euclidean algorithm, one controller and one datapath.
// Depends on mie_pkg, mie_ctrl, mie_datapath and assert_macros.svh.
//
// Usage:
//   Input channel: drive in_word_i (value, modulus) and raise start; the word is
//   taken at a rising edge where start is high and busy is low. busy stays high
//   until the result has been registered.
//   Result channel: done_o is high for exactly one cycle with result_o holding
//   inverse_out, gcd_out and status. The receiver cannot stall: the word is
//   taken at the end of that cycle. A new word may be started in that same cycle.
//   Sequence: each Euclid step runs setup (S_PREP), then one quotient bit per
//   cycle in the shared divider (S_DIV), then the update (S_STEP); a zero
//   modulus goes from S_PREP straight to S_FINAL with no division step.
//   The divider, one bit a cycle, sets the rate; one word is in work at a time.
//   Reset: asynchronous, active low; returns the controller to idle with no
//   result pending. Payload registers are not reset.
module modular_inverse_ext_euclid (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  mie_pkg::in_word_t  in_word_i,
  output logic               busy,
  output logic               done_o,
  output mie_pkg::out_word_t result_o
);

`include "assert_macros.svh"

  mie_pkg::ctrl_cmd_t  cmd;
  mie_pkg::dp_status_t dp_status;

  mie_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .status_i(dp_status),
    .cmd_o   (cmd),
    .busy    (busy),
    .done_o  (done_o)
  );

  mie_datapath u_datapath (
    .clk_i    (clk_i),
    .in_word_i(in_word_i),
    .cmd_i    (cmd),
    .status_o (dp_status),
    .result_o (result_o)
  );

  // Checks
  `MIE_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
  `MIE_ASSERT(a_done_single, done_o |=> !done_o, "result strobe held for two cycles")
  `MIE_ASSERT(a_ok_gcd_one,
              (done_o && result_o.status == mie_pkg::STATUS_OK) |->
              (result_o.gcd_out == mie_pkg::word_t'(1)),
              "inverse reported with gcd not one")
  `MIE_ASSERT_NEVER(a_fail_inv_zero,
                    done_o && result_o.status != mie_pkg::STATUS_OK &&
                    result_o.inverse_out != '0,
                    "failed job returned nonzero inverse")

endmodule
